// ===== src/kuf_pkg.sv =====
// ----------------------------------------------------------------------------
// kuf_pkg
// shared types, codes and the control store of the union-find edge filter
// ----------------------------------------------------------------------------
package kuf_pkg;

	// fixed field widths
	localparam int ID_W       = 12;
	localparam int WEIGHT_W   = 32;
	localparam int IN_DATA_W  = 56;
	localparam int OUT_DATA_W = 72;

	// default parameter values
	localparam int NODES_DEF       = 4096;
	localparam int WEIGHT_BITS_DEF = 32;
	localparam int ID_SPACE        = 1 << ID_W;

	// step counter
	localparam int STEP_W = 4;

	// program steps
	localparam logic [STEP_W-1:0] ST_CLR  = 4'd0;
	localparam logic [STEP_W-1:0] ST_IDLE = 4'd1;
	localparam logic [STEP_W-1:0] ST_CHK  = 4'd2;
	localparam logic [STEP_W-1:0] ST_MS   = 4'd3;
	localparam logic [STEP_W-1:0] ST_MD   = 4'd4;
	localparam logic [STEP_W-1:0] ST_FUS  = 4'd5;
	localparam logic [STEP_W-1:0] ST_CIS  = 4'd6;
	localparam logic [STEP_W-1:0] ST_CSS  = 4'd7;
	localparam logic [STEP_W-1:0] ST_FID  = 4'd8;
	localparam logic [STEP_W-1:0] ST_FUD  = 4'd9;
	localparam logic [STEP_W-1:0] ST_CID  = 4'd10;
	localparam logic [STEP_W-1:0] ST_CSD  = 4'd11;
	localparam logic [STEP_W-1:0] ST_LINK = 4'd12;
	localparam logic [STEP_W-1:0] ST_DONE = 4'd13;

	// read address select
	typedef enum logic [1:0] {
		RA_SRC,
		RA_DST,
		RA_NODE,
		RA_PAR
	} kuf_ra_t;

	// write select
	typedef enum logic [2:0] {
		WR_NONE,
		WR_CLR,
		WR_MARK,
		WR_COMP,
		WR_LINK
	} kuf_wr_t;

	// load select for the node and root registers
	typedef enum logic [1:0] {
		LD_HOLD,
		LD_SRC,
		LD_DST,
		LD_PAR
	} kuf_ld_t;

	// jump conditions
	typedef enum logic [2:0] {
		C_NONE,
		C_CLR_LAST,
		C_IN,
		C_ERR,
		C_ROOT,
		C_NODE_ROOT,
		C_OUT_FREE
	} kuf_cond_t;

	// one control word
	typedef struct packed {
		kuf_ra_t           ra_sel;
		kuf_wr_t           wr_sel;
		kuf_ld_t           node_ld;
		kuf_ld_t           root_ld;
		logic              rs_ld;
		logic              take;
		logic              link;
		logic              out_ld;
		kuf_cond_t         cond;
		logic              else_stay;
		logic [STEP_W-1:0] target;
	} kuf_uword_t;

	// datapath status seen by the sequencer
	typedef struct packed {
		logic clr_last;
		logic in_valid;
		logic err;
		logic par_root;
		logic node_root;
		logic out_free;
	} kuf_flags_t;

	// control store
	function automatic kuf_uword_t kuf_ucode(input logic [STEP_W-1:0] step);
		kuf_uword_t w;
		w = '{ra_sel: RA_SRC, wr_sel: WR_NONE, node_ld: LD_HOLD, root_ld: LD_HOLD,
			rs_ld: 1'b0, take: 1'b0, link: 1'b0, out_ld: 1'b0, cond: C_NONE,
			else_stay: 1'b0, target: ST_IDLE};
		case (step)
			ST_CLR: begin
				w.wr_sel    = WR_CLR;
				w.cond      = C_CLR_LAST;
				w.else_stay = 1'b1;
				w.target    = ST_IDLE;
			end
			ST_IDLE: begin
				w.take      = 1'b1;
				w.cond      = C_IN;
				w.else_stay = 1'b1;
				w.target    = ST_CHK;
			end
			ST_CHK: begin
				w.ra_sel = RA_SRC;
				w.cond   = C_ERR;
				w.target = ST_DONE;
			end
			ST_MS: begin
				w.wr_sel = WR_MARK;
				w.ra_sel = RA_DST;
			end
			ST_MD: begin
				w.wr_sel  = WR_MARK;
				w.ra_sel  = RA_SRC;
				w.node_ld = LD_SRC;
				w.root_ld = LD_SRC;
			end
			ST_FUS: begin
				w.ra_sel    = RA_PAR;
				w.root_ld   = LD_PAR;
				w.cond      = C_ROOT;
				w.else_stay = 1'b1;
				w.target    = ST_CIS;
			end
			ST_CIS: begin
				w.ra_sel = RA_NODE;
				w.cond   = C_NODE_ROOT;
				w.target = ST_FID;
			end
			ST_CSS: begin
				w.wr_sel    = WR_COMP;
				w.ra_sel    = RA_PAR;
				w.node_ld   = LD_PAR;
				w.cond      = C_ROOT;
				w.else_stay = 1'b1;
				w.target    = ST_FID;
			end
			ST_FID: begin
				w.rs_ld   = 1'b1;
				w.ra_sel  = RA_DST;
				w.node_ld = LD_DST;
				w.root_ld = LD_DST;
			end
			ST_FUD: begin
				w.ra_sel    = RA_PAR;
				w.root_ld   = LD_PAR;
				w.cond      = C_ROOT;
				w.else_stay = 1'b1;
				w.target    = ST_CID;
			end
			ST_CID: begin
				w.ra_sel = RA_NODE;
				w.cond   = C_NODE_ROOT;
				w.target = ST_LINK;
			end
			ST_CSD: begin
				w.wr_sel    = WR_COMP;
				w.ra_sel    = RA_PAR;
				w.node_ld   = LD_PAR;
				w.cond      = C_ROOT;
				w.else_stay = 1'b1;
				w.target    = ST_LINK;
			end
			ST_LINK: begin
				w.wr_sel = WR_LINK;
				w.link   = 1'b1;
			end
			ST_DONE: begin
				w.out_ld    = 1'b1;
				w.cond      = C_OUT_FREE;
				w.else_stay = 1'b1;
				w.target    = ST_IDLE;
			end
			default: begin
				w.target = ST_IDLE;
				w.cond   = C_NONE;
			end
		endcase
		// unused codes jump to idle on a valid input, else step on and wrap into the clearing pass
		if (step > ST_DONE) begin
			w.cond      = C_IN;
			w.take      = 1'b0;
			w.else_stay = 1'b0;
			w.target    = ST_IDLE;
		end
		return w;
	endfunction

endpackage

// ===== src/kruskal_union_find_edge_filter.sv =====
// ----------------------------------------------------------------------------
// kruskal_union_find_edge_filter
// spanning-forest edge filter over a disjoint-set parent table
// ----------------------------------------------------------------------------
// Takes one sorted weighted edge per transaction and returns one result per
// edge. After reset the block runs a clearing pass over the parent store of
// min(NODES, 4096) entries with s_axis_tready low. An edge in range has its
// source and target entries marked, walks the source to its root hop by hop,
// compresses that path, does the same for the target and links the two roots
// before the result register is loaded; every step is one microcode step
// against the parent store's one read and one write port. An edge with an id
// at or above NODES goes from the range check straight to the result step,
// which returns to idle, so the next edge can be accepted in the cycle after
// the result is loaded at the earliest. A finished result sits in the output
// register, so the next edge is taken while it waits.
module kruskal_union_find_edge_filter
	import kuf_pkg::*;
#(
	parameter int NODES       = NODES_DEF,
	parameter int WEIGHT_BITS = WEIGHT_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// source_node [11:0], target_node [23:12], edge_weight [55:24]
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// edge_kept [0], id_error [1], source_echo [13:2], target_echo [25:14],
	// weight_echo [57:26], merged_root [69:58], zero fill [71:70]
	output logic [OUT_DATA_W-1:0] m_axis_tdata
);

	kuf_uword_t uword;
	kuf_flags_t flags;

	kuf_sequencer u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.flags  (flags),
		.uword  (uword)
	);

	kuf_datapath #(
		.NODES       (NODES),
		.WEIGHT_BITS (WEIGHT_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.uword         (uword),
		.flags         (flags),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

endmodule

// ===== src/kuf_parent_ram.sv =====
// ----------------------------------------------------------------------------
// kuf_parent_ram
// single write, single read parent store with registered, write-first read
// ----------------------------------------------------------------------------
module kuf_parent_ram
	import kuf_pkg::*;
#(
	parameter int DEPTH  = NODES_DEF,
	parameter int ADDR_W = $clog2(DEPTH),
	parameter int DATA_W = ADDR_W + 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [DEPTH];
	logic [DATA_W-1:0] mem_q;
	logic [DATA_W-1:0] wdata_q;
	logic              fwd_q;

	// storage array
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		mem_q   <= mem[raddr];
		wdata_q <= wdata;
	end

	// bypass flag for a read of the address written in the same cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_q <= 1'b0;
		end else begin
			fwd_q <= we && (waddr == raddr);
		end
	end

	assign rdata = fwd_q ? wdata_q : mem_q;

endmodule

// ===== src/kuf_sequencer.sv =====
// ----------------------------------------------------------------------------
// kuf_sequencer
// step counter and control store with conditional jumps
// ----------------------------------------------------------------------------
module kuf_sequencer
	import kuf_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  kuf_flags_t flags,
	output kuf_uword_t uword
);

	logic [STEP_W-1:0] step_q;
	logic              hit;

	assign uword = kuf_ucode(step_q);

	// condition select
	always_comb begin
		case (uword.cond)
			C_NONE:      hit = 1'b0;
			C_CLR_LAST:  hit = flags.clr_last;
			C_IN:        hit = flags.in_valid;
			C_ERR:       hit = flags.err;
			C_ROOT:      hit = flags.par_root;
			C_NODE_ROOT: hit = flags.node_root;
			C_OUT_FREE:  hit = flags.out_free;
			default:     hit = 1'b0;
		endcase
	end

	// step counter, clearing pass first after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= ST_CLR;
		end else if (hit) begin
			step_q <= uword.target;
		end else if (!uword.else_stay) begin
			step_q <= step_q + 1'b1;
		end
	end

endmodule

// ===== src/kuf_datapath.sv =====
// ----------------------------------------------------------------------------
// kuf_datapath
// edge registers, find and compress registers, parent store and result stage
// ----------------------------------------------------------------------------
module kuf_datapath
	import kuf_pkg::*;
#(
	parameter int NODES       = NODES_DEF,
	parameter int WEIGHT_BITS = WEIGHT_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  kuf_uword_t            uword,
	output kuf_flags_t            flags,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [OUT_DATA_W-1:0] m_axis_tdata
);

	localparam int DEPTH  = (NODES < ID_SPACE) ? NODES : ID_SPACE;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int ENT_W  = ADDR_W + 1;
	localparam int WB     = (WEIGHT_BITS < WEIGHT_W) ? WEIGHT_BITS : WEIGHT_W;

	// edge registers
	logic [ID_W-1:0]   src_q;
	logic [ID_W-1:0]   dst_q;
	logic [WB-1:0]     weight_q;
	logic              err_q;
	logic              kept_q;
	logic [ADDR_W-1:0] merged_q;

	// walk registers
	logic [ADDR_W-1:0] node_q;
	logic [ADDR_W-1:0] root_q;
	logic [ADDR_W-1:0] rs_q;
	logic [ADDR_W-1:0] raddr_q;
	logic [ADDR_W-1:0] clr_q;

	// output stage
	logic              out_valid_q;
	logic              out_kept_q;
	logic              out_err_q;
	logic [ID_W-1:0]   out_src_q;
	logic [ID_W-1:0]   out_dst_q;
	logic [WB-1:0]     out_weight_q;
	logic [ADDR_W-1:0] out_merged_q;

	logic              accept;
	logic              in_err;
	logic [ID_W-1:0]   in_src;
	logic [ID_W-1:0]   in_dst;
	logic              out_free;
	logic [ADDR_W-1:0] src_a;
	logic [ADDR_W-1:0] dst_a;
	logic [ADDR_W-1:0] raddr;
	logic              we;
	logic [ADDR_W-1:0] waddr;
	logic [ENT_W-1:0]  wdata;
	logic [ENT_W-1:0]  rdata;
	logic              rd_seen;
	logic [ADDR_W-1:0] par;
	logic              rs_lower;
	logic [ADDR_W-1:0] lo_root;
	logic [ADDR_W-1:0] hi_root;

	assign in_src        = s_axis_tdata[ID_W-1:0];
	assign in_dst        = s_axis_tdata[2*ID_W-1:ID_W];
	assign in_err        = (32'(in_src) >= NODES) || (32'(in_dst) >= NODES);
	assign s_axis_tready = uword.take;
	assign accept        = s_axis_tvalid && uword.take;
	assign out_free      = !out_valid_q || m_axis_tready;

	assign src_a = src_q[ADDR_W-1:0];
	assign dst_a = dst_q[ADDR_W-1:0];

	// an entry never marked reads as its own root
	assign rd_seen = rdata[ENT_W-1];
	assign par     = rd_seen ? rdata[ADDR_W-1:0] : raddr_q;

	assign rs_lower = rs_q < root_q;
	assign lo_root  = rs_lower ? rs_q : root_q;
	assign hi_root  = rs_lower ? root_q : rs_q;

	// status for the sequencer
	assign flags = '{clr_last: (clr_q == ADDR_W'(DEPTH - 1)), in_valid: s_axis_tvalid,
		err: err_q, par_root: (par == root_q), node_root: (node_q == root_q),
		out_free: out_free};

	// read address select
	always_comb begin
		case (uword.ra_sel)
			RA_SRC:  raddr = src_a;
			RA_DST:  raddr = dst_a;
			RA_NODE: raddr = node_q;
			RA_PAR:  raddr = par;
			default: raddr = src_a;
		endcase
	end

	// write port select
	always_comb begin
		we    = 1'b0;
		waddr = clr_q;
		wdata = '0;
		case (uword.wr_sel)
			WR_CLR: begin
				we    = 1'b1;
				waddr = clr_q;
				wdata = '0;
			end
			WR_MARK: begin
				we    = !rd_seen;
				waddr = raddr_q;
				wdata = {1'b1, raddr_q};
			end
			WR_COMP: begin
				we    = 1'b1;
				waddr = node_q;
				wdata = {1'b1, root_q};
			end
			WR_LINK: begin
				we    = rs_q != root_q;
				waddr = hi_root;
				wdata = {1'b1, lo_root};
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	kuf_parent_ram #(
		.DEPTH  (DEPTH),
		.ADDR_W (ADDR_W),
		.DATA_W (ENT_W)
	) u_ram (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (we),
		.waddr  (waddr),
		.wdata  (wdata),
		.raddr  (raddr),
		.rdata  (rdata)
	);

	// clearing pass counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (uword.wr_sel == WR_CLR) begin
			clr_q <= clr_q + 1'b1;
		end
	end

	// edge capture and result flags
	always_ff @(posedge clk) begin
		raddr_q <= raddr;
		if (accept) begin
			src_q    <= in_src;
			dst_q    <= in_dst;
			weight_q <= s_axis_tdata[2*ID_W +: WB];
			err_q    <= in_err;
			kept_q   <= 1'b0;
			merged_q <= '0;
		end
		if (uword.link) begin
			kept_q   <= rs_q != root_q;
			merged_q <= lo_root;
		end
	end

	// node, root and first root registers
	always_ff @(posedge clk) begin
		case (uword.node_ld)
			LD_SRC:  node_q <= src_a;
			LD_DST:  node_q <= dst_a;
			LD_PAR:  node_q <= par;
			default: node_q <= node_q;
		endcase
		case (uword.root_ld)
			LD_SRC:  root_q <= src_a;
			LD_DST:  root_q <= dst_a;
			LD_PAR:  root_q <= par;
			default: root_q <= root_q;
		endcase
		if (uword.rs_ld) begin
			rs_q <= root_q;
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (uword.out_ld && out_free) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (uword.out_ld && out_free) begin
			out_kept_q   <= kept_q;
			out_err_q    <= err_q;
			out_src_q    <= src_q;
			out_dst_q    <= dst_q;
			out_weight_q <= weight_q;
			out_merged_q <= merged_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {2'b00, ID_W'(out_merged_q), WEIGHT_W'(out_weight_q),
		out_dst_q, out_src_q, out_err_q, out_kept_q};

endmodule
